// File: sv/gbs_pkg.sv
package gbs_pkg;

    // fixed field widths
    localparam int VALW  = 16;
    localparam int LABW  = 5;
    localparam int CFGW  = 5;
    localparam int BFW   = 4;
    localparam int IMPW  = 18;
    localparam int STW   = 2;
    localparam int QBITS = 16;

    // running best before the first candidate: 3.0 in Q16
    localparam logic [IMPW-1:0] BEST_START = IMPW'(3 << QBITS);

    // result status codes
    localparam logic [STW-1:0] ST_FOUND    = 2'd0;
    localparam logic [STW-1:0] ST_FEW      = 2'd1;
    localparam logic [STW-1:0] ST_OVERFLOW = 2'd2;

    // register index
    localparam int REG_NUM_FEATURES = 0;

    // controller to datapath
    typedef struct packed {
        logic load_en;
        logic srch_init;
        logic thr_rd;
        logic thr_cap;
        logic scan_rd;
        logic div_l;
        logic div_r;
        logic cmp;
        logic out_load;
    } gbs_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic few;
        logic last_s;
        logic last_cand;
        logic div_done;
        logic out_free;
    } gbs_stat_t;

endpackage

// File: sv/gbs_ram.sv
module gbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/gbs_div.sv
module gbs_div #(
    parameter int NW = 9
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [NW-1:0]               n,
    input  logic [2*NW-1:0]             sq,
    output logic                        done,
    output logic [gbs_pkg::QBITS-1:0]   quo
);

    localparam int RW = 2 * NW + 1;
    localparam int CNTW = $clog2(gbs_pkg::QBITS + 1);

    typedef enum logic [1:0] {D_IDLE, D_MUL, D_RUN} dstate_t;

    dstate_t                   state_reg;
    logic [NW-1:0]             n_reg;
    logic [2*NW-1:0]           sq_reg;
    logic [RW-1:0]             nn_reg;
    logic [RW-1:0]             rem_reg;
    logic [gbs_pkg::QBITS-1:0] q_reg;
    logic [CNTW-1:0]           cnt_reg;
    logic                      zero_reg;
    logic                      done_reg;
    logic [2*NW-1:0]           prod;
    logic [RW-1:0]             rem2;

    assign prod = (2*NW)'(n_reg) * (2*NW)'(n_reg);
    assign rem2 = {rem_reg[RW-2:0], 1'b0};

    // gini = floor(2^16 * (n*n - sq) / (n*n)), zero for n of 0 or 1, one quotient bit a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        n_reg     <= n;
                        sq_reg    <= sq;
                        state_reg <= D_MUL;
                    end
                end
                D_MUL:
                begin
                    nn_reg    <= RW'(prod);
                    rem_reg   <= RW'(prod - sq_reg);
                    zero_reg  <= (n_reg <= NW'(1));
                    cnt_reg   <= '0;
                    q_reg     <= '0;
                    state_reg <= D_RUN;
                end
                D_RUN:
                begin
                    if (rem2 >= nn_reg)
                    begin
                        rem_reg <= rem2 - nn_reg;
                        q_reg   <= {q_reg[gbs_pkg::QBITS-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem2;
                        q_reg   <= {q_reg[gbs_pkg::QBITS-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + CNTW'(1);
                    if (cnt_reg == CNTW'(gbs_pkg::QBITS - 1))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign quo  = zero_reg ? '0 : q_reg;

endmodule

// File: sv/gbs_ctrl.sv
module gbs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_last,
    output logic                in_stall,
    input  gbs_pkg::gbs_stat_t  stat,
    output gbs_pkg::gbs_cmd_t   cmd
);

    typedef enum logic [3:0] {
        S_LOAD, S_START, S_THR_ADDR, S_THR_CAP, S_SCAN, S_SCAN_END,
        S_DIV_L, S_WAIT_L, S_DIV_R, S_WAIT_R, S_CMP, S_OUT
    } state_t;

    state_t state_reg;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            unique case (state_reg)
                S_LOAD:     if (in_valid && in_last) state_reg <= S_START;
                S_START:    state_reg <= stat.few ? S_OUT : S_THR_ADDR;
                S_THR_ADDR: state_reg <= S_THR_CAP;
                S_THR_CAP:  state_reg <= S_SCAN;
                S_SCAN:     if (stat.last_s) state_reg <= S_SCAN_END;
                S_SCAN_END: state_reg <= S_DIV_L;
                S_DIV_L:    state_reg <= S_WAIT_L;
                S_WAIT_L:   if (stat.div_done) state_reg <= S_DIV_R;
                S_DIV_R:    state_reg <= S_WAIT_R;
                S_WAIT_R:   if (stat.div_done) state_reg <= S_CMP;
                S_CMP:      state_reg <= stat.last_cand ? S_OUT : S_THR_ADDR;
                S_OUT:      if (stat.out_free) state_reg <= S_LOAD;
                default:    state_reg <= S_LOAD;
            endcase
        end
    end

    // command decode
    always_comb
    begin
        cmd           = '0;
        cmd.load_en   = (state_reg == S_LOAD) && in_valid;
        cmd.srch_init = (state_reg == S_START);
        cmd.thr_rd    = (state_reg == S_THR_ADDR);
        cmd.thr_cap   = (state_reg == S_THR_CAP);
        cmd.scan_rd   = (state_reg == S_SCAN);
        cmd.div_l     = (state_reg == S_DIV_L);
        cmd.div_r     = (state_reg == S_DIV_R);
        cmd.cmp       = (state_reg == S_CMP);
        cmd.out_load  = (state_reg == S_OUT) && stat.out_free;
    end

    assign in_stall = (state_reg != S_LOAD);

endmodule

// File: sv/gbs_dp.sv
module gbs_dp #(
    parameter int MAX_SAMPLES  = 256,
    parameter int MAX_FEATURES = 16,
    parameter int NUM_CLASSES  = 26
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  gbs_pkg::gbs_cmd_t                  cmd,
    output gbs_pkg::gbs_stat_t                 stat,
    input  logic                               cfg_we,
    input  logic [gbs_pkg::CFGW-1:0]           cfg_wdata,
    output logic [gbs_pkg::CFGW-1:0]           cfg_rdata,
    input  logic signed [gbs_pkg::VALW-1:0]    feature_value,
    input  logic [gbs_pkg::LABW-1:0]           class_label,
    input  logic                               last_value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [gbs_pkg::BFW-1:0]            best_feature,
    output logic signed [gbs_pkg::VALW-1:0]    best_threshold,
    output logic [gbs_pkg::IMPW-1:0]           best_impurity,
    output logic [gbs_pkg::STW-1:0]            status
);

    localparam int VALW = gbs_pkg::VALW;
    localparam int NW   = $clog2(MAX_SAMPLES + 1);
    localparam int SW   = $clog2(MAX_SAMPLES);
    localparam int FW   = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int NFW  = $clog2(MAX_FEATURES + 1);
    localparam int CXW  = (NFW > gbs_pkg::CFGW) ? NFW : gbs_pkg::CFGW;
    localparam int CW   = $clog2(NUM_CLASSES);
    localparam int LXW  = (CW > gbs_pkg::LABW) ? CW : gbs_pkg::LABW;
    localparam int AW   = $clog2(MAX_SAMPLES * MAX_FEATURES);
    localparam int MW   = NFW + CW;
    localparam int FEW  = (FW > gbs_pkg::BFW) ? FW : gbs_pkg::BFW;
    localparam int QW   = gbs_pkg::QBITS;

    // configuration and effective feature count
    logic [gbs_pkg::CFGW-1:0] nf_cfg_reg;
    logic [CXW-1:0]           nf_eff;
    logic [CXW-1:0]           nf_raw;

    assign nf_raw = CXW'(nf_cfg_reg);

    always_comb
    begin
        if (nf_raw == '0)
            nf_eff = CXW'(1);
        else if (nf_raw > CXW'(MAX_FEATURES))
            nf_eff = CXW'(MAX_FEATURES);
        else
            nf_eff = nf_raw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            nf_cfg_reg <= gbs_pkg::CFGW'(1);
        else if (cfg_we)
            nf_cfg_reg <= cfg_wdata;
    end

    assign cfg_rdata = nf_cfg_reg;

    // load side
    logic [FW-1:0]  fp_reg;
    logic [NW-1:0]  cnt_reg;
    logic           ovf_reg;
    logic [CW-1:0]  lab_reg;
    logic [NW-1:0]  n_srch_reg;
    logic           ovf_srch_reg;
    logic [FW-1:0]  fp_c;
    logic           room;
    logic           end_s;
    logic [CW-1:0]  lab_sat;
    logic [CW-1:0]  lab_use;
    logic [NW-1:0]  cnt_new;
    logic           ovf_new;
    logic [AW-1:0]  v_waddr;
    logic [MW-1:0]  m_wdata;
    logic           v_we;
    logic           m_we;

    assign fp_c  = (CXW'(fp_reg) >= nf_eff) ? FW'(nf_eff - CXW'(1)) : fp_reg;
    assign room  = (cnt_reg < NW'(MAX_SAMPLES));
    assign end_s = ((CXW'(fp_c) + CXW'(1)) >= nf_eff) || last_value;
    assign lab_sat = (LXW'(class_label) >= LXW'(NUM_CLASSES)) ?
                     CW'(NUM_CLASSES - 1) : CW'(class_label);
    assign lab_use = (fp_c == '0) ? lab_sat : lab_reg;
    assign cnt_new = (end_s && room) ? cnt_reg + NW'(1) : cnt_reg;
    assign ovf_new = ovf_reg || (end_s && !room);
    assign v_waddr = AW'(AW'(cnt_reg[SW-1:0]) * AW'(MAX_FEATURES)) + AW'(fp_c);
    assign m_wdata = {NFW'(NFW'(fp_c) + NFW'(1)), lab_use};
    assign v_we    = cmd.load_en && room;
    assign m_we    = cmd.load_en && room && end_s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fp_reg  <= '0;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (cmd.load_en)
        begin
            fp_reg <= end_s ? '0 : FW'(fp_c + FW'(1));
            if (last_value)
            begin
                cnt_reg <= '0;
                ovf_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_new;
                ovf_reg <= ovf_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_en && (fp_c == '0))
            lab_reg <= lab_sat;
        if (cmd.load_en && last_value)
        begin
            n_srch_reg   <= cnt_new;
            ovf_srch_reg <= ovf_new;
        end
    end

    // search counters
    logic [FW-1:0]  f_reg;
    logic [SW-1:0]  i_reg;
    logic [SW-1:0]  s_reg;
    logic           pv_reg;
    logic [SW-1:0]  n_last;
    logic [SW-1:0]  rsel;
    logic [AW-1:0]  v_raddr;
    logic [VALW-1:0] v_rdata;
    logic [MW-1:0]  m_rdata;
    logic [NFW-1:0] fill_q;
    logic [CW-1:0]  lab_q;
    logic signed [VALW-1:0] val_eff;

    assign n_last  = SW'(n_srch_reg - NW'(1));
    assign rsel    = cmd.thr_rd ? i_reg : s_reg;
    assign v_raddr = AW'(AW'(rsel) * AW'(MAX_FEATURES)) + AW'(f_reg);
    assign fill_q  = m_rdata[MW-1:CW];
    assign lab_q   = m_rdata[CW-1:0];
    assign val_eff = (NFW'(f_reg) < fill_q) ? $signed(v_rdata) : '0;

    gbs_ram #(.WIDTH(VALW), .DEPTH(MAX_SAMPLES * MAX_FEATURES)) u_values (
        .clk   (clk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (feature_value),
        .raddr (v_raddr),
        .rdata (v_rdata)
    );

    gbs_ram #(.WIDTH(MW), .DEPTH(MAX_SAMPLES)) u_meta (
        .clk   (clk),
        .we    (m_we),
        .waddr (cnt_reg[SW-1:0]),
        .wdata (m_wdata),
        .raddr (rsel),
        .rdata (m_rdata)
    );

    // class counts for the current candidate
    logic signed [VALW-1:0] thr_reg;
    logic [NW-1:0]   lc_reg [NUM_CLASSES];
    logic [NW-1:0]   rc_reg [NUM_CLASSES];
    logic [NW-1:0]   nl_reg;
    logic [NW-1:0]   nr_reg;
    logic [2*NW-1:0] sql_reg;
    logic [2*NW-1:0] sqr_reg;
    logic            go_left;

    assign go_left = (val_eff <= thr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= 1'b0;
        else
            pv_reg <= cmd.scan_rd;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.srch_init)
        begin
            f_reg <= '0;
            i_reg <= '0;
        end
        if (cmd.thr_cap)
        begin
            thr_reg <= val_eff;
            s_reg   <= '0;
            nl_reg  <= '0;
            nr_reg  <= '0;
            sql_reg <= '0;
            sqr_reg <= '0;
            for (int k = 0; k < NUM_CLASSES; k++)
            begin
                lc_reg[k] <= '0;
                rc_reg[k] <= '0;
            end
        end
        if (cmd.scan_rd)
            s_reg <= s_reg + SW'(1);
        // sum of squares grows by 2c+1 when a count steps up
        if (pv_reg)
        begin
            if (go_left)
            begin
                lc_reg[lab_q] <= lc_reg[lab_q] + NW'(1);
                sql_reg <= sql_reg + {(NW)'(0), lc_reg[lab_q]} +
                           {(NW)'(0), lc_reg[lab_q]} + (2*NW)'(1);
                nl_reg  <= nl_reg + NW'(1);
            end
            else
            begin
                rc_reg[lab_q] <= rc_reg[lab_q] + NW'(1);
                sqr_reg <= sqr_reg + {(NW)'(0), rc_reg[lab_q]} +
                           {(NW)'(0), rc_reg[lab_q]} + (2*NW)'(1);
                nr_reg  <= nr_reg + NW'(1);
            end
        end
        if (cmd.cmp)
        begin
            if (i_reg == n_last)
            begin
                i_reg <= '0;
                f_reg <= f_reg + FW'(1);
            end
            else
            begin
                i_reg <= i_reg + SW'(1);
            end
        end
    end

    // shared gini divider
    logic          div_done;
    logic [QW-1:0] div_q;
    logic          side_reg;
    logic [QW-1:0] gl_reg;
    logic [QW-1:0] gr_reg;

    gbs_div #(.NW(NW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_l || cmd.div_r),
        .n     (cmd.div_r ? nr_reg : nl_reg),
        .sq    (cmd.div_r ? sqr_reg : sql_reg),
        .done  (div_done),
        .quo   (div_q)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.div_l)
            side_reg <= 1'b0;
        if (cmd.div_r)
            side_reg <= 1'b1;
        if (div_done)
        begin
            if (side_reg)
                gr_reg <= div_q;
            else
                gl_reg <= div_q;
        end
    end

    // running best
    logic [gbs_pkg::IMPW-1:0] score;
    logic [gbs_pkg::IMPW-1:0] best_reg;
    logic [FW-1:0]            bf_reg;
    logic signed [VALW-1:0]   bt_reg;
    logic [FEW-1:0]           bf_ext;

    assign score  = gbs_pkg::IMPW'(gl_reg) + gbs_pkg::IMPW'(gr_reg);
    assign bf_ext = FEW'(bf_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.srch_init)
        begin
            best_reg <= gbs_pkg::BEST_START;
            bf_reg   <= '0;
            bt_reg   <= '0;
        end
        else if (cmd.cmp && (score < best_reg))
        begin
            best_reg <= score;
            bf_reg   <= f_reg;
            bt_reg   <= thr_reg;
        end
    end

    // output word register
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (n_srch_reg < NW'(2))
            begin
                best_feature   <= '0;
                best_threshold <= '0;
                best_impurity  <= '0;
                status         <= gbs_pkg::ST_FEW;
            end
            else
            begin
                best_feature   <= bf_ext[gbs_pkg::BFW-1:0];
                best_threshold <= bt_reg;
                best_impurity  <= best_reg;
                status         <= ovf_srch_reg ? gbs_pkg::ST_OVERFLOW : gbs_pkg::ST_FOUND;
            end
        end
    end

    assign out_valid = out_valid_reg;

    // status to controller
    always_comb
    begin
        stat           = '0;
        stat.few       = (n_srch_reg < NW'(2));
        stat.last_s    = (s_reg == n_last);
        stat.last_cand = (i_reg == n_last) && (CXW'(f_reg) == nf_eff - CXW'(1));
        stat.div_done  = div_done;
        stat.out_free  = !out_valid_reg || !out_stall;
    end

endmodule

// File: sv/gini_best_split_finder.sv
// channel   direction  signals
// in        input      in_valid, in_stall, feature_value, class_label, last_value
// out       output     out_valid, out_stall, best_feature, best_threshold,
//                      best_impurity, status
// cfg       input      psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// loading takes one word per cycle into the sample value memory while in_stall is low
// the search runs after the last word with the input stalled: for each of
// nf*n candidates, a threshold read, a scan through the value memory,
// the two divisions (left then right) and one compare
// reset brings num_features to 1 and clears the load sample count
// a result waiting under out_stall does not hold up loading of the next set
module gini_best_split_finder #(
    parameter int MAX_SAMPLES  = 256,
    parameter int MAX_FEATURES = 16,
    parameter int NUM_CLASSES  = 26
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [gbs_pkg::VALW-1:0]    feature_value,
    input  logic [gbs_pkg::LABW-1:0]           class_label,
    input  logic                               last_value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [gbs_pkg::BFW-1:0]            best_feature,
    output logic signed [gbs_pkg::VALW-1:0]    best_threshold,
    output logic [gbs_pkg::IMPW-1:0]           best_impurity,
    output logic [gbs_pkg::STW-1:0]            status,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [1:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    gbs_pkg::gbs_cmd_t        cmd;
    gbs_pkg::gbs_stat_t       stat;
    logic                     cfg_we;
    logic                     hit;
    logic [gbs_pkg::CFGW-1:0] cfg_rdata;

    // register port
    assign hit    = (paddr == 2'(gbs_pkg::REG_NUM_FEATURES * 4));
    assign cfg_we = psel && penable && pwrite && hit;
    assign pready = 1'b1;
    assign prdata = hit ? 32'(cfg_rdata) : 32'd0;

    gbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_last  (last_value),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    gbs_dp #(
        .MAX_SAMPLES  (MAX_SAMPLES),
        .MAX_FEATURES (MAX_FEATURES),
        .NUM_CLASSES  (NUM_CLASSES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_wdata      (pwdata[gbs_pkg::CFGW-1:0]),
        .cfg_rdata      (cfg_rdata),
        .feature_value  (feature_value),
        .class_label    (class_label),
        .last_value     (last_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .best_feature   (best_feature),
        .best_threshold (best_threshold),
        .best_impurity  (best_impurity),
        .status         (status)
    );

endmodule
